// ----- rtl/integer_sum_min_max_na_unit_macros.svh -----
// Assertion macros shared by the integer sum/min/max reduction RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef INTEGER_SUM_MIN_MAX_NA_UNIT_MACROS_SVH
`define INTEGER_SUM_MIN_MAX_NA_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISMM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ismm_pkg.sv -----
// Package for the integer sum/min/max reduction unit: widths, codes and types.
// Depends on nothing; imported by every other RTL file of the block but the macro header.
`timescale 1ns / 1ps

package ismm_pkg;

   // Widths of the element, the running accumulator and the CSR port.
   localparam int ELEM_WIDTH     = 32;
   localparam int ACC_WIDTH      = 64;
   localparam int CSR_ADDR_WIDTH = 8;
   localparam int CSR_DATA_WIDTH = 32;

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic signed [ACC_WIDTH-1:0]  acc_type;
   typedef logic [1:0]                   mode_type;
   typedef logic [1:0]                   status_type;

   // Reduction modes; the unused code behaves as a sum.
   localparam mode_type MODE_SUM = 2'd0;
   localparam mode_type MODE_MIN = 2'd1;
   localparam mode_type MODE_MAX = 2'd2;

   // Result status codes.
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_MISSING  = 2'd1;
   localparam status_type STATUS_OVERFLOW = 2'd2;
   localparam status_type STATUS_EMPTY    = 2'd3;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_REDUCE_MODE  = CSR_ADDR_WIDTH'(0);
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SKIP_MISSING = CSR_ADDR_WIDTH'(1);

   // The most negative element code marks a missing element.
   localparam elem_type MISSING_CODE = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

   // Saturation limits of the accumulator.
   localparam acc_type ACC_HIGH = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam acc_type ACC_LOW  = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   // Valid range of a final sum: plus and minus the largest element.
   localparam acc_type INT_TOP    = acc_type'({1'b0, {(ELEM_WIDTH-1){1'b1}}});
   localparam acc_type INT_BOTTOM = -INT_TOP;

   typedef struct packed {
      mode_type reduce_mode;
      logic     skip_missing;
   } cfg_type;

   typedef struct packed {
      elem_type   reduced_value;
      status_type reduce_status;
   } result_type;

endpackage

// ----- rtl/ismm_ifs.sv -----
// Handshake channel interfaces of the integer sum/min/max reduction unit.
// Depends on ismm_pkg for the payload types.
`timescale 1ns / 1ps

// Element channel: one element of a vector per transaction.
interface ismm_req_if;
   import ismm_pkg::*;
   logic     valid;
   logic     ready;
   elem_type element_value;
   logic     last_element;

   modport source (output valid, output element_value, output last_element, input ready);
   modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

// Result channel: one reduced value per vector.
interface ismm_rsp_if;
   import ismm_pkg::*;
   logic       valid;
   logic       ready;
   elem_type   reduced_value;
   status_type reduce_status;

   modport source (output valid, output reduced_value, output reduce_status, input ready);
   modport sink   (input valid, input reduced_value, input reduce_status, output ready);
endinterface

// Configuration write channel.
interface ismm_csr_if;
   import ismm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_ADDR_WIDTH-1:0] reg_index;
   logic [CSR_DATA_WIDTH-1:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- rtl/ismm_csr.sv -----
// Configuration registers of the integer sum/min/max reduction unit.
// Depends on ismm_pkg and the ismm_csr_if interface.
`timescale 1ns / 1ps

module ismm_csr (
   input  logic              clock,
   input  logic              reset,
   ismm_csr_if.sink          csr_if,
   output ismm_pkg::cfg_type cfg
);
   import ismm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   // Writes are always taken.
   assign csr_if.ready = 1'b1;
   assign wr_en        = csr_if.valid;

   // Decode the register index; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_if.reg_index)
            CSR_REDUCE_MODE:  cfg_in.reduce_mode  = csr_if.wr_data[1:0];
            CSR_SKIP_MISSING: cfg_in.skip_missing = csr_if.wr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/ismm_fold.sv -----
// Accumulator and fold logic of the integer sum/min/max reduction unit.
// Depends on ismm_pkg.
`timescale 1ns / 1ps

module ismm_fold (
   input  logic                 clock,
   input  logic                 reset,
   input  ismm_pkg::cfg_type    cfg,
   input  logic                 advance,
   input  ismm_pkg::elem_type   element_value,
   input  logic                 last_element,
   output ismm_pkg::result_type result
);
   import ismm_pkg::*;

   acc_type                accumulator_ff;
   acc_type                accumulator_in;
   logic                   any_contributed_ff;
   logic                   any_contributed_in;
   logic                   missing_latched_ff;
   logic                   missing_latched_in;

   logic                   is_missing;
   acc_type                x_ext;
   logic signed [ACC_WIDTH:0] sum_wide;
   acc_type                sum_sat;
   acc_type                fold_val;
   acc_type                acc_upd;
   logic                   any_upd;
   logic                   miss_upd;
   logic                   sum_mode;

   assign is_missing = (element_value == MISSING_CODE);
   assign x_ext      = acc_type'(element_value);
   assign sum_mode   = (cfg.reduce_mode != MODE_MIN) && (cfg.reduce_mode != MODE_MAX);

   // Saturating add: one extra bit shows when the sum leaves the accumulator range.
   always_comb begin
      sum_wide = {accumulator_ff[ACC_WIDTH-1], accumulator_ff}
               + {x_ext[ACC_WIDTH-1], x_ext};
      if (sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1]) begin
         sum_sat = sum_wide[ACC_WIDTH] ? ACC_LOW : ACC_HIGH;
      end else begin
         sum_sat = acc_type'(sum_wide[ACC_WIDTH-1:0]);
      end
   end

   // Fold the element under the current mode.
   always_comb begin
      case (cfg.reduce_mode)
         MODE_MIN: fold_val = (!any_contributed_ff || (x_ext < accumulator_ff))
                              ? x_ext : accumulator_ff;
         MODE_MAX: fold_val = (!any_contributed_ff || (x_ext > accumulator_ff))
                              ? x_ext : accumulator_ff;
         default:  fold_val = sum_sat;
      endcase
   end

   // Once a missing element is latched, the rest of the vector is ignored.
   always_comb begin
      if (missing_latched_ff || is_missing) begin
         acc_upd = accumulator_ff;
         any_upd = any_contributed_ff;
      end else begin
         acc_upd = fold_val;
         any_upd = 1'b1;
      end
      miss_upd = missing_latched_ff || (is_missing && !cfg.skip_missing);
   end

   // Judge the vector as it stands after this element.
   always_comb begin
      if (miss_upd) begin
         result.reduced_value = MISSING_CODE;
         result.reduce_status = STATUS_MISSING;
      end else if (!any_upd) begin
         result.reduced_value = '0;
         result.reduce_status = STATUS_EMPTY;
      end else if (sum_mode && ((acc_upd > INT_TOP) || (acc_upd < INT_BOTTOM))) begin
         result.reduced_value = MISSING_CODE;
         result.reduce_status = STATUS_OVERFLOW;
      end else begin
         result.reduced_value = elem_type'(acc_upd[ELEM_WIDTH-1:0]);
         result.reduce_status = STATUS_OK;
      end
   end

   // The last element of a vector clears the state for the next one.
   always_comb begin
      accumulator_in     = accumulator_ff;
      any_contributed_in = any_contributed_ff;
      missing_latched_in = missing_latched_ff;
      if (advance) begin
         if (last_element) begin
            accumulator_in     = '0;
            any_contributed_in = 1'b0;
            missing_latched_in = 1'b0;
         end else begin
            accumulator_in     = acc_upd;
            any_contributed_in = any_upd;
            missing_latched_in = miss_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accumulator_ff     <= '0;
         any_contributed_ff <= 1'b0;
         missing_latched_ff <= 1'b0;
      end else begin
         accumulator_ff     <= accumulator_in;
         any_contributed_ff <= any_contributed_in;
         missing_latched_ff <= missing_latched_in;
      end
   end

endmodule

// ----- rtl/integer_sum_min_max_na_unit.sv -----
// Top level of the integer sum/min/max reduction unit with missing-value handling.
// Depends on ismm_pkg, the channel interfaces, ismm_csr, ismm_fold and the macro header.
`timescale 1ns / 1ps

// The unit folds a stream of signed 32-bit elements into their sum, minimum or
// maximum and gives one result transaction on the element flagged last. It takes
// one element per cycle unless a last element is held up. Each element is accepted
// into the input register and folded from there; for a last element, the result is
// loaded into the result register as it leaves the input register. While a
// result waits on a stalled result channel, a last element stays in the input
// register and holds off new elements. The rate is set by the fold stage: one
// 64-bit saturating add or compare into the accumulator, followed by the range
// check of the final sum, per element. Element codes of -2147483648 are missing
// values: with skip_missing clear they force a missing result, with it set they
// are passed over. Configuration is to be written through the CSR channel only
// while no vector is in flight; the unit itself does not enforce this.

`include "integer_sum_min_max_na_unit_macros.svh"

module integer_sum_min_max_na_unit (
   input  logic       clock,
   input  logic       reset,
   ismm_req_if.sink   req_if,
   ismm_rsp_if.source rsp_if,
   ismm_csr_if.sink   csr_if
);
   import ismm_pkg::*;

   cfg_type    cfg;
   result_type result;

   // Input register.
   logic       s1_valid_ff;
   logic       s1_valid_in;
   elem_type   s1_value_ff;
   logic       s1_last_ff;

   // Result register.
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_data_ff;

   logic       req_accept;
   logic       out_free;
   logic       s1_advance;
   logic       rsp_load;

   ismm_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   ismm_fold u_fold (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .advance       (s1_advance),
      .element_value (s1_value_ff),
      .last_element  (s1_last_ff),
      .result        (result)
   );

   // Only a last element needs room in the result register.
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign s1_advance   = s1_valid_ff && (!s1_last_ff || out_free);
   assign rsp_load     = s1_advance && s1_last_ff;
   assign req_if.ready = !s1_valid_ff || s1_advance;
   assign req_accept   = req_if.valid && req_if.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_value_ff <= req_if.element_value;
         s1_last_ff  <= req_if.last_element;
      end
      if (rsp_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.reduced_value = rsp_data_ff.reduced_value;
   assign rsp_if.reduce_status = rsp_data_ff.reduce_status;

   // A last element waiting behind a stalled result must hold off new elements.
   `ISMM_ASSERT_SAME(a_stall_blocks_input, clock, reset,
      s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_if.ready,
      !req_if.ready, "Input accepted while a last element is blocked")
   // A last element that leaves the input register becomes a result transaction.
   `ISMM_ASSERT_NEXT(a_last_gives_result, clock, reset,
      s1_advance && s1_last_ff, rsp_valid_ff, "Last element produced no result")
   // Missing and overflow results carry the missing code.
   `ISMM_ASSERT_SAME(a_missing_code, clock, reset,
      rsp_valid_ff && (rsp_data_ff.reduce_status == STATUS_MISSING ||
                       rsp_data_ff.reduce_status == STATUS_OVERFLOW),
      rsp_data_ff.reduced_value == MISSING_CODE, "Missing result without missing code")
   // An empty vector reduces to zero.
   `ISMM_ASSERT_SAME(a_empty_zero, clock, reset,
      rsp_valid_ff && rsp_data_ff.reduce_status == STATUS_EMPTY,
      rsp_data_ff.reduced_value == '0, "Empty result is not zero")

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for integer_sum_min_max_na_unit: sum, minimum and maximum reduction
// with missing elements. Depends on ismm_pkg, the channel interfaces and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;
   import ismm_pkg::*;

   localparam int          CLOCK_PERIOD   = 20;
   localparam int          SETTLE_CYCLES  = 6;
   localparam int          CYCLE_LIMIT    = 400000;
   localparam int          RANDOM_PHASES  = 6;
   localparam int          PHASE_ELEMENTS = 90;
   localparam mode_type    MODE_UNUSED    = 2'd3;
   localparam elem_type    ELEM_MAX       = 32'sh7fffffff;
   localparam elem_type    ELEM_MIN_VALID = 32'sh80000001;
   localparam logic [CSR_ADDR_WIDTH-1:0] FIRST_UNUSED_INDEX = CSR_SKIP_MISSING + 1'b1;

   typedef struct {
      elem_type value;
      logic     last_el;
   } element_txn_type;

   logic clock;
   logic reset;

   ismm_req_if req_ch ();
   ismm_rsp_if rsp_ch ();
   ismm_csr_if csr_ch ();

   integer_sum_min_max_na_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Elements waiting for the driver and results the model still owes.
   element_txn_type pending_elements[$];
   result_type      expected_results[$];

   // Register copies and running vector state of the model.
   mode_type cur_mode       = MODE_SUM;
   logic     cur_skip       = 1'b0;
   acc_type  running_value  = '0;
   logic     contributed    = 1'b0;
   logic     missing_seen   = 1'b0;

   bit          idle_on        = 1'b1;
   bit          req_taken      = 1'b0;
   int unsigned send_gap       = 0;
   int unsigned stall_left     = 0;
   int unsigned error_count    = 0;
   int unsigned elements_taken = 0;
   int unsigned results_seen   = 0;
   int unsigned config_writes  = 0;
   int unsigned cycle_count    = 0;

   // Clock, plus known values on every input from time zero.
   initial begin
      clock               = 1'b0;
      req_ch.valid        = 1'b0;
      req_ch.element_value = '0;
      req_ch.last_element = 1'b0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.reg_index    = '0;
      csr_ch.wr_data      = '0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Reset is held at the start of the run only.
   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Mostly short gaps, now and then a long one; none while idling is off.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Folds one accepted element into the model and queues a result on the last one.
   task automatic fold_element(input elem_type v, input logic last_el);
      acc_type                   x;
      logic signed [ACC_WIDTH:0] wide_sum;
      result_type                r;
      if (!missing_seen) begin
         if (v == MISSING_CODE) begin
            if (!cur_skip) missing_seen = 1'b1;
         end else begin
            x = {{(ACC_WIDTH - ELEM_WIDTH){v[ELEM_WIDTH-1]}}, v};
            if (cur_mode == MODE_MIN) begin
               if (!contributed || x < running_value) running_value = x;
            end else if (cur_mode == MODE_MAX) begin
               if (!contributed || x > running_value) running_value = x;
            end else begin
               // The accumulator saturates at its own width.
               wide_sum = running_value + x;
               if (wide_sum > ACC_HIGH) running_value = ACC_HIGH;
               else if (wide_sum < ACC_LOW) running_value = ACC_LOW;
               else running_value = wide_sum[ACC_WIDTH-1:0];
            end
            contributed = 1'b1;
         end
      end
      if (last_el) begin
         if (missing_seen) begin
            r.reduced_value = MISSING_CODE;
            r.reduce_status = STATUS_MISSING;
         end else if (!contributed) begin
            r.reduced_value = '0;
            r.reduce_status = STATUS_EMPTY;
         end else if (cur_mode != MODE_MIN && cur_mode != MODE_MAX &&
                      (running_value > INT_TOP || running_value < INT_BOTTOM)) begin
            r.reduced_value = MISSING_CODE;
            r.reduce_status = STATUS_OVERFLOW;
         end else begin
            r.reduced_value = running_value[ELEM_WIDTH-1:0];
            r.reduce_status = STATUS_OK;
         end
         expected_results.push_back(r);
         running_value = '0;
         contributed   = 1'b0;
         missing_seen  = 1'b0;
      end
   endtask

   // Element driver: holds each transaction until it is taken, then maybe a gap.
   always @(negedge clock) begin
      element_txn_type item;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_elements.size() > 0) begin
            item = pending_elements.pop_front();
            req_ch.valid         <= 1'b1;
            req_ch.element_value <= item.value;
            req_ch.last_element  <= item.last_el;
            send_gap = pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stall runs on ready.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // Monitor: checks each result transaction, tracks register writes, runs the model.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         cur_mode      = MODE_SUM;
         cur_skip      = 1'b0;
         running_value = '0;
         contributed   = 1'b0;
         missing_seen  = 1'b0;
         req_taken     = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result value %0d status %0d", $time,
                        rsp_ch.reduced_value, rsp_ch.reduce_status);
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.reduced_value !== want.reduced_value) begin
                  error_count++;
                  $display("%0t: reduced_value expected %0d actual %0d", $time,
                           want.reduced_value, rsp_ch.reduced_value);
               end
               if (rsp_ch.reduce_status !== want.reduce_status) begin
                  error_count++;
                  $display("%0t: reduce_status expected %0d actual %0d", $time,
                           want.reduce_status, rsp_ch.reduce_status);
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.reg_index == CSR_REDUCE_MODE) cur_mode = csr_ch.wr_data[1:0];
            else if (csr_ch.reg_index == CSR_SKIP_MISSING) cur_skip = csr_ch.wr_data[0];
         end
         req_taken = req_ch.valid && req_ch.ready;
         if (req_taken) begin
            elements_taken++;
            fold_element(req_ch.element_value, req_ch.last_element);
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send(input elem_type v, input logic last_el);
      element_txn_type item;
      item.value   = v;
      item.last_el = last_el;
      pending_elements.push_back(item);
   endtask

   // Holds the sender until every element is taken and every result has come,
   // then lets the pipeline settle.
   task automatic wait_idle();
      @(posedge clock);
      while (pending_elements.size() != 0 || req_ch.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_ADDR_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= index;
      csr_ch.wr_data   <= data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      config_writes++;
   endtask

   // Register writes carry random upper bits, which the unit must mask off.
   task automatic set_mode(input mode_type m);
      logic [CSR_DATA_WIDTH-1:0] data;
      data      = $urandom();
      data[1:0] = m;
      write_register(CSR_REDUCE_MODE, data);
   endtask

   task automatic set_skip(input logic s);
      logic [CSR_DATA_WIDTH-1:0] data;
      data    = $urandom();
      data[0] = s;
      write_register(CSR_SKIP_MISSING, data);
   endtask

   // An index outside the register map must change nothing.
   task automatic write_unused_index();
      write_register(CSR_ADDR_WIDTH'($urandom_range(FIRST_UNUSED_INDEX,
                                                    (1 << CSR_ADDR_WIDTH) - 1)),
                     $urandom());
   endtask

   function automatic elem_type pick_element(input bit big, input bit noisy);
      elem_type v;
      if (noisy && $urandom_range(0, 1)) return MISSING_CODE;
      case ($urandom_range(0, 15))
         0:       v = MISSING_CODE;
         1:       v = ELEM_MAX;
         2:       v = ELEM_MIN_VALID;
         3, 4:    v = int'($urandom_range(0, 16)) - 8;
         default: begin
            v = $urandom();
            // Large magnitudes push sums out of range within a few elements.
            if (big) v[30] = ~v[31];
         end
      endcase
      return v;
   endfunction

   // Stimulus: directed cases first, then random phases under varied settings.
   initial begin
      int unsigned count;
      int unsigned len;
      bit          big;
      bit          noisy;
      bit          paused;
      mode_type    phase_mode;

      wait (reset === 1'b0);

      // Sum with skipping off, as after reset: range edges and a missing element.
      send(ELEM_MAX, 1'b1);
      send(ELEM_MAX, 1'b0);
      send(32'sd1, 1'b1);
      send(ELEM_MIN_VALID, 1'b1);
      send(ELEM_MIN_VALID, 1'b0);
      send(-32'sd1, 1'b1);
      send(32'sd5, 1'b0);
      send(MISSING_CODE, 1'b0);
      send(32'sd7, 1'b1);
      send(32'sd0, 1'b1);
      wait_idle();

      // Skipping on: a vector of only missing elements, and one with a single value.
      set_skip(1'b1);
      write_unused_index();
      send(MISSING_CODE, 1'b0);
      send(MISSING_CODE, 1'b1);
      send(MISSING_CODE, 1'b0);
      send(-32'sd3, 1'b0);
      send(MISSING_CODE, 1'b1);
      wait_idle();

      set_mode(MODE_MIN);
      send(32'sd4, 1'b0);
      send(ELEM_MAX, 1'b0);
      send(ELEM_MIN_VALID, 1'b1);
      wait_idle();

      set_mode(MODE_MAX);
      send(-32'sd9, 1'b0);
      send(-32'sd2, 1'b0);
      send(MISSING_CODE, 1'b1);
      wait_idle();

      // The unused mode code folds as a sum, overflow included.
      set_mode(MODE_UNUSED);
      send(ELEM_MAX, 1'b0);
      send(ELEM_MAX, 1'b1);
      wait_idle();

      // Mode change inside a vector: summed so far, then judged as a maximum.
      set_mode(MODE_SUM);
      send(32'sd10, 1'b0);
      send(32'sd20, 1'b0);
      wait_idle();
      set_mode(MODE_MAX);
      send(32'sd5, 1'b1);
      wait_idle();

      // Random phases, each under its own settings; one runs with no idling.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0:       phase_mode = MODE_SUM;
            1:       phase_mode = MODE_MIN;
            2:       phase_mode = MODE_MAX;
            default: phase_mode = MODE_UNUSED;
         endcase
         if (phase == RANDOM_PHASES - 2) phase_mode = mode_type'($urandom_range(0, 3));
         idle_on = (phase != 3);
         set_mode(phase_mode);
         set_skip(phase[0]);
         if ($urandom_range(0, 1)) write_unused_index();

         count  = 0;
         paused = 1'b0;
         while (count < PHASE_ELEMENTS) begin
            if (len == 0 || $urandom_range(0, 9) != 0) len = $urandom_range(1, 6);
            else len = $urandom_range(9, 24);
            big   = ($urandom_range(0, 3) == 0);
            noisy = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < len; i++) send(pick_element(big, noisy), i == len - 1);
            count += len;
            // Halfway through, the sender waits for every owed result.
            if (!paused && count >= PHASE_ELEMENTS / 2) begin
               paused = 1'b1;
               wait_idle();
            end
         end

         // Sometimes leave a vector open across the next register writes.
         if (phase != RANDOM_PHASES - 1 && $urandom_range(0, 1)) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) send(pick_element(1'b0, 1'b0), 1'b0);
         end
         wait_idle();
      end

      $display("Covered %0d element transactions and %0d result transactions",
               elements_taken, results_seen);
      $display("across %0d register writes in all modes, with and without skipping",
               config_writes);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
